FILE: design/rmh_pkg.sv
// Shared types and constants for the two-heap running median block.
`timescale 1ns / 1ps
package rmh_pkg;

  localparam int MOD_W = 16;
  localparam logic [MOD_W-1:0] MOD_RESET = 16'd10000;
  localparam int SUM_W = MOD_W + 1;

  typedef enum logic {
    HEAP_LOWER,
    HEAP_UPPER
  } heap_sel_t;

  typedef enum logic {
    MOD_MEDIAN,
    MOD_SUM
  } mod_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_ROUTE,
    S_SD_TEST,
    S_SD_RDR,
    S_SD_CMP,
    S_PUSH_GO,
    S_PU_TEST,
    S_PU_CMP,
    S_MED,
    S_SUM,
    S_MOD1,
    S_MOD2,
    S_FIN
  } rmh_state_t;

  typedef struct packed {
    logic     capture;
    logic     plan;
    logic     sd_init;
    logic     push_init;
    logic     rd_parent;
    logic     rd_left;
    logic     rd_right;
    logic     lat_left;
    logic     wr_key;
    logic     pu_move_wr;
    logic     sd_move_wr;
    logic     med_load;
    logic     sum_direct;
    logic     mod_start;
    mod_src_t mod_src;
    logic     sum_from_mod;
    logic     out_load;
  } rmh_cmd_t;

  typedef struct packed {
    logic drop;
    logic rep;
    logic at_root;
    logic pu_move;
    logic sd_leaf;
    logic sd_move;
    logic mod_busy;
    logic mod_zero;
  } rmh_sts_t;

endpackage

FILE: design/rmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rmh_ctrl.sv
// Sequencer for insert, rebalance, median sum and result transfer.
`timescale 1ns / 1ps
module rmh_ctrl import rmh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rmh_sts_t sts,
  output rmh_cmd_t cmd
);

  rmh_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mod_src   = MOD_MEDIAN;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_ROUTE;
      end
      S_ROUTE: begin
        if (sts.drop) begin
          state_nxt = S_MED;
        end else if (sts.rep) begin
          cmd.sd_init = 1'b1;
          state_nxt   = S_SD_TEST;
        end else begin
          cmd.push_init = 1'b1;
          state_nxt     = S_PU_TEST;
        end
      end
      S_SD_TEST: begin
        if (sts.sd_leaf) begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_PUSH_GO;
        end else begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_SD_RDR;
        end
      end
      S_SD_RDR: begin
        cmd.lat_left = 1'b1;
        cmd.rd_right = 1'b1;
        state_nxt    = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (sts.sd_move) begin
          cmd.sd_move_wr = 1'b1;
          state_nxt      = S_SD_TEST;
        end else begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_PUSH_GO;
        end
      end
      S_PUSH_GO: begin
        cmd.push_init = 1'b1;
        state_nxt     = S_PU_TEST;
      end
      S_PU_TEST: begin
        if (sts.at_root) begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_MED;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (sts.pu_move) begin
          cmd.pu_move_wr = 1'b1;
          state_nxt      = S_PU_TEST;
        end else begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_MED;
        end
      end
      S_MED: begin
        cmd.med_load = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        if (sts.drop) begin
          state_nxt = S_FIN;
        end else if (sts.mod_zero) begin
          cmd.sum_direct = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD1;
        end
      end
      S_MOD1: begin
        if (!sts.mod_busy) begin
          cmd.mod_start = 1'b1;
          cmd.mod_src   = MOD_SUM;
          state_nxt     = S_MOD2;
        end
      end
      S_MOD2: begin
        if (!sts.mod_busy) begin
          cmd.sum_from_mod = 1'b1;
          state_nxt        = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_key, cmd.pu_move_wr, cmd.sd_move_wr}))
    else $error("more than one heap write command");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

endmodule

FILE: design/rmh_dp.sv
// Heap storage, heap walk registers, counts, and serial modulo datapath.
`timescale 1ns / 1ps
module rmh_dp import rmh_pkg::*; #(
  parameter int HALF_CAPACITY = 1024,
  parameter int VALUE_WIDTH   = 32,
  localparam int CW = $clog2(HALF_CAPACITY + 1),
  localparam int HW = $clog2(2 * HALF_CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmh_cmd_t                      cmd,
  output rmh_sts_t                      sts,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_restart,
  input  logic [MOD_W-1:0]              modulus,
  output logic signed [VALUE_WIDTH-1:0] median,
  output logic [MOD_W-1:0]              median_sum_mod,
  output logic [HW-1:0]                 held_count,
  output logic                          dropped
);

  localparam int VW  = VALUE_WIDTH;
  localparam int IW  = $clog2(HALF_CAPACITY);
  localparam int LW  = IW + 2;
  localparam int DW  = (VW > SUM_W) ? VW : SUM_W;
  localparam int MCW = $clog2(DW + 1);
  localparam int EW  = (VW > MOD_W) ? VW : MOD_W;

  logic signed [VW-1:0] v_r, ltop_r, utop_r, key_r, key2_r, dl_r, med_r;
  logic [CW-1:0]        lc_r, uc_r;
  logic [MOD_W-1:0]     sum_r, rem_r;
  logic [DW-1:0]        div_r;
  logic [MCW-1:0]       mcnt_r;
  logic                 drop_r, rep_r;
  heap_sel_t            rep_heap_r, push_heap_r, sel_r;
  logic [IW-1:0]        idx_r;

  // plan
  logic                 up_side, p_drop, p_rep;
  heap_sel_t            p_rep_heap, p_push_heap;
  logic signed [VW-1:0] p_key2;

  always_comb begin
    up_side     = (uc_r != '0) && (v_r >= utop_r);
    p_drop      = 1'b0;
    p_rep       = 1'b0;
    p_rep_heap  = HEAP_LOWER;
    p_push_heap = HEAP_LOWER;
    p_key2      = v_r;
    if (up_side) begin
      if (lc_r == uc_r) begin
        p_drop      = (lc_r >= CW'(HALF_CAPACITY));
        p_rep       = (v_r > utop_r);
        p_rep_heap  = HEAP_UPPER;
        p_push_heap = HEAP_LOWER;
        p_key2      = p_rep ? utop_r : v_r;
      end else begin
        p_drop      = (uc_r >= CW'(HALF_CAPACITY));
        p_push_heap = HEAP_UPPER;
      end
    end else begin
      if (lc_r > uc_r) begin
        p_drop      = (uc_r >= CW'(HALF_CAPACITY));
        p_rep       = (v_r < ltop_r);
        p_rep_heap  = HEAP_LOWER;
        p_push_heap = HEAP_UPPER;
        p_key2      = p_rep ? ltop_r : v_r;
      end else begin
        p_drop      = (lc_r >= CW'(HALF_CAPACITY));
        p_push_heap = HEAP_LOWER;
      end
    end
  end

  // heap walk
  logic                 is_max, has_right, right_pick;
  logic [CW-1:0]        cnt_sel, cnt_push;
  logic [LW-1:0]        left_i, right_i;
  logic [IW-1:0]        parent_i, best_i;
  logic signed [VW-1:0] rdata_lo, rdata_up, rdata_sel, best_val, wdata;
  logic                 we, re;
  logic [IW-1:0]        raddr;

  assign is_max    = (sel_r == HEAP_LOWER);
  assign cnt_sel   = (sel_r == HEAP_UPPER) ? uc_r : lc_r;
  assign cnt_push  = (push_heap_r == HEAP_UPPER) ? uc_r : lc_r;
  assign left_i    = LW'({idx_r, 1'b1});
  assign right_i   = left_i + 1'b1;
  assign parent_i  = (idx_r - 1'b1) >> 1;
  assign has_right = right_i < LW'(cnt_sel);
  assign rdata_sel = (sel_r == HEAP_UPPER) ? rdata_up : rdata_lo;

  always_comb begin
    right_pick = has_right &&
                 (is_max ? (rdata_sel > dl_r) : (rdata_sel < dl_r));
    best_val   = right_pick ? rdata_sel : dl_r;
    best_i     = right_pick ? right_i[IW-1:0] : left_i[IW-1:0];
  end

  assign we    = cmd.wr_key | cmd.pu_move_wr | cmd.sd_move_wr;
  assign wdata = cmd.wr_key ? key_r : (cmd.pu_move_wr ? rdata_sel : best_val);
  assign re    = cmd.rd_parent | cmd.rd_left | (cmd.rd_right & has_right);
  assign raddr = cmd.rd_parent ? parent_i :
                 (cmd.rd_left ? left_i[IW-1:0] : right_i[IW-1:0]);

  rmh_ram #(.WIDTH(VW), .DEPTH(HALF_CAPACITY)) u_lower (
    .clk(clk), .we(we && (sel_r == HEAP_LOWER)), .waddr(idx_r), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata_lo)
  );

  rmh_ram #(.WIDTH(VW), .DEPTH(HALF_CAPACITY)) u_upper (
    .clk(clk), .we(we && (sel_r == HEAP_UPPER)), .waddr(idx_r), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata_up)
  );

  // modulo
  logic                 med_neg;
  logic [VW-1:0]        mag;
  logic [MOD_W-1:0]     r1;
  logic [SUM_W-1:0]     sum_plus, trial;
  logic signed [EW-1:0] med_ext;

  assign med_neg  = med_r[VW-1];
  assign mag      = med_neg ? (VW'(0) - med_r) : med_r;
  assign r1       = (med_neg && (rem_r != '0)) ? (modulus - rem_r) : rem_r;
  assign sum_plus = {1'b0, sum_r} + {1'b0, r1};
  assign trial    = {rem_r, div_r[DW-1]};
  assign med_ext  = EW'(med_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r   <= '0;
      uc_r   <= '0;
      sum_r  <= '0;
      mcnt_r <= '0;
    end else begin
      if (cmd.capture && in_restart) begin
        lc_r  <= '0;
        uc_r  <= '0;
        sum_r <= '0;
      end
      if (cmd.push_init) begin
        if (push_heap_r == HEAP_UPPER) begin
          uc_r <= uc_r + 1'b1;
        end else begin
          lc_r <= lc_r + 1'b1;
        end
      end
      if (cmd.sum_direct) begin
        sum_r <= sum_r + med_ext[MOD_W-1:0];
      end else if (cmd.sum_from_mod) begin
        sum_r <= rem_r;
      end
      if (cmd.mod_start) begin
        mcnt_r <= MCW'(DW);
      end else if (mcnt_r != '0) begin
        mcnt_r <= mcnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r <= in_value;
    end
    if (cmd.plan) begin
      drop_r      <= p_drop;
      rep_r       <= p_rep;
      rep_heap_r  <= p_rep_heap;
      push_heap_r <= p_push_heap;
      key2_r      <= p_key2;
    end
    if (cmd.sd_init) begin
      sel_r <= rep_heap_r;
      key_r <= v_r;
      idx_r <= '0;
    end else if (cmd.push_init) begin
      sel_r <= push_heap_r;
      key_r <= key2_r;
      idx_r <= cnt_push[IW-1:0];
    end else if (cmd.pu_move_wr) begin
      idx_r <= parent_i;
    end else if (cmd.sd_move_wr) begin
      idx_r <= best_i;
    end
    if (cmd.lat_left) begin
      dl_r <= rdata_sel;
    end
    // keep a copy of each heap top
    if (we && (idx_r == '0)) begin
      if (sel_r == HEAP_UPPER) begin
        utop_r <= wdata;
      end else begin
        ltop_r <= wdata;
      end
    end
    if (cmd.med_load) begin
      med_r <= (lc_r != '0) ? ltop_r : '0;
    end
    if (cmd.mod_start) begin
      div_r <= (cmd.mod_src == MOD_SUM) ? DW'(sum_plus) : DW'(mag);
      rem_r <= '0;
    end else if (mcnt_r != '0) begin
      div_r <= div_r << 1;
      rem_r <= (trial >= SUM_W'(modulus)) ? MOD_W'(trial - SUM_W'(modulus))
                                          : trial[MOD_W-1:0];
    end
    if (cmd.out_load) begin
      median         <= med_r;
      median_sum_mod <= sum_r;
      held_count     <= HW'(lc_r) + HW'(uc_r);
      dropped        <= drop_r;
    end
  end

  always_comb begin
    sts          = '0;
    sts.drop     = drop_r;
    sts.rep      = rep_r;
    sts.at_root  = (idx_r == '0);
    sts.pu_move  = is_max ? (key_r > rdata_sel) : (key_r < rdata_sel);
    sts.sd_leaf  = left_i >= LW'(cnt_sel);
    sts.sd_move  = is_max ? (best_val > key_r) : (best_val < key_r);
    sts.mod_busy = (mcnt_r != '0);
    sts.mod_zero = (modulus == '0);
  end

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (lc_r <= CW'(HALF_CAPACITY)) && (uc_r <= CW'(HALF_CAPACITY)))
    else $error("heap count beyond capacity");

  a_bal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> ((lc_r == uc_r) || ({1'b0, lc_r} == ({1'b0, uc_r} + 1'b1))))
    else $error("heaps out of balance");

  a_mod: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_from_mod |-> (rem_r < modulus))
    else $error("remainder not below modulus");

endmodule

FILE: design/running_median_two_heaps.sv
// Top level: register port, sequencer and heap datapath of the running median.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | in_value, in_restart
//   out     | output    | out_valid / out_ready   | out_median, out_median_sum_mod,
//           |           |                         | out_held_count, out_dropped
//   cfg     | input     | cfg_psel/penable/pready | register 0: modulus
//
// One item at a time. An insert may first walk the sift-down path, then walks the
// sift-up path (log2 of the heap size levels each). Unless the item is dropped or
// the modulus is zero, the sum update takes two passes of the one-bit-per-cycle
// remainder unit, each over max(VALUE_WIDTH,17) dividend bits.
// Synchronous active-low reset empties both heaps, the sum and the output stage.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module running_median_two_heaps import rmh_pkg::*; #(
  parameter int HALF_CAPACITY = 1024,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_median,
  output logic [MOD_W-1:0]              out_median_sum_mod,
  output logic [$clog2(2*HALF_CAPACITY+1)-1:0] out_held_count,
  output logic                          out_dropped,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [MOD_W-1:0] modulus_r;
  rmh_cmd_t         cmd;
  rmh_sts_t         sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      modulus_r <= cfg_pwdata[MOD_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-MOD_W){1'b0}}, modulus_r};

  rmh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rmh_dp #(.HALF_CAPACITY(HALF_CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_value(in_value), .in_restart(in_restart), .modulus(modulus_r),
    .median(out_median), .median_sum_mod(out_median_sum_mod),
    .held_count(out_held_count), .dropped(out_dropped)
  );

endmodule
